/* sv/nae_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NFA acceptance engine package
// Shared sizes, request and response types, and codes for the engine.
// ----------------------------------------------------------------------------
package nae_pkg;

    localparam int unsigned NUM_STATES  = 64;
    localparam int unsigned NUM_SYMBOLS = 16;
    localparam int unsigned ROW_COUNT   = NUM_STATES * NUM_SYMBOLS;
    localparam int unsigned ROW_AW      = $clog2(ROW_COUNT);
    localparam int unsigned STATE_W     = $clog2(NUM_STATES);

    localparam int unsigned FUNC_W      = 2;
    localparam int unsigned STATE_FLD_W = 6;
    localparam int unsigned SYMBOL_W    = 4;
    localparam int unsigned ALPHA_W     = 5;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 64;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(16);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_FEED   = 2'd2,
        FUNC_END    = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHABET_SIZE = 2'd0,
        CFG_INITIAL_SET   = 2'd1,
        CFG_FINAL_SET     = 2'd2
    } t_cfg_idx;

    typedef logic [NUM_STATES-1:0] t_set;

    typedef struct packed {
        t_func                  func;
        logic [STATE_FLD_W-1:0] from_state;
        logic [STATE_FLD_W-1:0] to_state;
        logic [SYMBOL_W-1:0]    symbol;
    } t_req;

    typedef struct packed {
        logic sample_done;
        logic accepted;
        logic any_active;
        logic bad_item;
    } t_rsp;

    typedef struct packed {
        logic [ALPHA_W-1:0] alphabet_size;
        t_set               initial_set;
        t_set               final_set;
    } t_cfg;

endpackage

/* sv/nae_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one engine request.
// ----------------------------------------------------------------------------
interface nae_req_if;
    import nae_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FUNC_W-1:0]      func;
    logic [STATE_FLD_W-1:0] from_state;
    logic [STATE_FLD_W-1:0] to_state;
    logic [SYMBOL_W-1:0]    symbol;

    modport source (output valid, output func, output from_state, output to_state,
                    output symbol, input ready);
    modport sink (input valid, input func, input from_state, input to_state,
                  input symbol, output ready);
endinterface

/* sv/nae_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one engine response.
// ----------------------------------------------------------------------------
interface nae_rsp_if;
    logic valid;
    logic ready;
    logic sample_done;
    logic accepted;
    logic any_active;
    logic bad_item;

    modport source (output valid, output sample_done, output accepted,
                    output any_active, output bad_item, input ready);
    modport sink (input valid, input sample_done, input accepted,
                  input any_active, input bad_item, output ready);
endinterface

/* sv/nae_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nae_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/nae_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NFA engine sequencer
// Clears the successor table, edits rows by read-modify-write and walks all
// state rows of a symbol to build the next active set.
// ----------------------------------------------------------------------------
module nae_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nae_pkg::t_cfg  i_cfg,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  nae_pkg::t_req  i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_free,
    output nae_pkg::t_rsp  o_rsp
);
    import nae_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDIT,
        ST_WALK,
        ST_FINISH
    } t_state;

    localparam logic [ROW_AW-1:0]  LAST_ROW   = ROW_AW'(ROW_COUNT - 1);
    localparam logic [STATE_W-1:0] LAST_STATE = STATE_W'(NUM_STATES - 1);
    localparam logic [ROW_AW-1:0]  ROW_STRIDE = ROW_AW'(NUM_SYMBOLS);

    t_state              r_state, n_state;
    logic [ROW_AW-1:0]   r_clr, n_clr;
    logic [ROW_AW-1:0]   r_addr, n_addr;
    logic [STATE_W-1:0]  r_q, n_q;
    t_set                r_active, n_active;
    t_set                r_cur, n_cur;
    t_set                r_next, n_next;
    logic                r_fresh, n_fresh;
    t_func               r_func, n_func;
    logic [STATE_W-1:0]  r_to, n_to;
    logic                r_done, n_done;
    logic                r_acc, n_acc;
    logic                r_bad, n_bad;

    logic                ram_we;
    logic [ROW_AW-1:0]   ram_waddr;
    t_set                ram_wdata;
    logic                ram_re;
    logic [ROW_AW-1:0]   ram_raddr;
    t_set                ram_rdata;

    logic                sym_ok;
    logic                states_ok;
    logic [ROW_AW-1:0]   edit_row;
    t_set                start_set;
    t_set                to_bit;
    t_set                walk_acc;

    nae_ram #(
        .WIDTH (NUM_STATES),
        .DEPTH (ROW_COUNT)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        sym_ok    = ({1'b0, i_req.symbol} < i_cfg.alphabet_size) &&
                    (32'(i_req.symbol) < NUM_SYMBOLS);
        states_ok = (32'(i_req.from_state) < NUM_STATES) &&
                    (32'(i_req.to_state) < NUM_STATES);
        edit_row  = ROW_AW'(ROW_AW'(i_req.from_state) * ROW_STRIDE) +
                    ROW_AW'(i_req.symbol);
        start_set = r_fresh ? i_cfg.initial_set : r_active;
        to_bit    = t_set'(1) << r_to;
        walk_acc  = r_next | (r_cur[r_q] ? ram_rdata : '0);

        n_state  = r_state;
        n_clr    = r_clr;
        n_addr   = r_addr;
        n_q      = r_q;
        n_active = r_active;
        n_cur    = r_cur;
        n_next   = r_next;
        n_fresh  = r_fresh;
        n_func   = r_func;
        n_to     = r_to;
        n_done   = r_done;
        n_acc    = r_acc;
        n_bad    = r_bad;

        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = r_addr;
        o_rsp_valid = 1'b0;
        o_req_ready = (r_state == ST_IDLE);

        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                if (r_clr == LAST_ROW) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_done  = 1'b0;
                    n_acc   = 1'b0;
                    n_bad   = 1'b0;
                    n_func  = i_req.func;
                    n_to    = STATE_W'(i_req.to_state);
                    n_state = ST_FINISH;
                    case (i_req.func)
                        FUNC_ADD, FUNC_REMOVE: begin
                            if (!sym_ok || !states_ok) begin
                                n_bad = 1'b1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = edit_row;
                                n_addr    = edit_row;
                                n_state   = ST_EDIT;
                            end
                        end
                        FUNC_FEED: begin
                            if (!sym_ok) begin
                                n_bad = 1'b1;
                            end else begin
                                // Row of state zero for this symbol.
                                ram_re    = 1'b1;
                                ram_raddr = ROW_AW'(i_req.symbol);
                                n_addr    = ROW_AW'(i_req.symbol);
                                n_cur     = start_set;
                                n_next    = '0;
                                n_q       = '0;
                                n_state   = ST_WALK;
                            end
                        end
                        default: begin
                            n_active = start_set;
                            n_acc    = |(start_set & i_cfg.final_set);
                            n_done   = 1'b1;
                            n_fresh  = 1'b1;
                        end
                    endcase
                end
            end
            ST_EDIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = (r_func == FUNC_ADD) ? (ram_rdata | to_bit)
                                                 : (ram_rdata & ~to_bit);
                n_state   = ST_FINISH;
            end
            ST_WALK: begin
                if (r_q == LAST_STATE) begin
                    n_active = walk_acc;
                    n_fresh  = 1'b0;
                    n_state  = ST_FINISH;
                end else begin
                    n_next    = walk_acc;
                    n_q       = r_q + 1'b1;
                    ram_re    = 1'b1;
                    ram_raddr = r_addr + ROW_STRIDE;
                    n_addr    = r_addr + ROW_STRIDE;
                end
            end
            ST_FINISH: begin
                if (i_rsp_free) begin
                    o_rsp_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        o_rsp.sample_done = r_done;
        o_rsp.accepted    = r_acc;
        o_rsp.any_active  = |r_active;
        o_rsp.bad_item    = r_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_active <= '0;
            r_fresh  <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_active <= n_active;
            r_fresh  <= n_fresh;
        end
        r_addr <= n_addr;
        r_q    <= n_q;
        r_cur  <= n_cur;
        r_next <= n_next;
        r_func <= n_func;
        r_to   <= n_to;
        r_done <= n_done;
        r_acc  <= n_acc;
        r_bad  <= n_bad;
    end
endmodule

/* sv/nfa_acceptance_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NFA acceptance engine
// Bit-parallel simulation of a nondeterministic automaton over a successor
// table held in block RAM, with a configuration register file and a
// registered response stage.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake           Contents
//   i_req     in         valid / ready       func, from_state, to_state, symbol
//   o_rsp     out        valid / ready       sample_done, accepted, any_active,
//                                            bad_item
//   i_cfg_*   in         write enable only   register index, 64-bit data
//
// An add or remove request is accepted with the row read, then writes the row
// and gives its response. A fed symbol walks every state row of that symbol
// through the single RAM read port, one row per cycle, then gives its
// response. Ending a sample and any flagged request go straight from
// acceptance to the response.
// After reset the table is cleared one row per cycle, which keeps the request
// channel stalled until all NUM_STATES * NUM_SYMBOLS rows (1024 at the default
// sizes) are cleared; configuration writes are taken during that pass.
// The response register lets the next request be accepted while the previous
// response still waits on o_rsp.ready.
// ----------------------------------------------------------------------------
module nfa_acceptance_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    nae_req_if.sink                        i_req,
    nae_rsp_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [nae_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nae_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import nae_pkg::*;

    // Configuration registers. Only the bits of the state sets that name real
    // states are kept; the rest never take part in any result.
    logic [ALPHA_W-1:0] r_alphabet_size;
    t_set               r_initial_set;
    t_set               r_final_set;
    t_cfg               cfg;

    // Response stage.
    logic               r_rsp_valid;
    t_rsp               r_rsp;

    t_req               core_req;
    logic               core_rsp_valid;
    logic               core_rsp_free;
    t_rsp               core_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet_size <= ALPHA_RESET;
            r_initial_set   <= '0;
            r_final_set     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALPHABET_SIZE: r_alphabet_size <= i_cfg_data[ALPHA_W-1:0];
                CFG_INITIAL_SET:   r_initial_set   <= i_cfg_data[NUM_STATES-1:0];
                CFG_FINAL_SET:     r_final_set     <= i_cfg_data[NUM_STATES-1:0];
                default: begin
                    // Writes past the register list are dropped.
                end
            endcase
        end
    end

    assign cfg.alphabet_size = r_alphabet_size;
    assign cfg.initial_set   = r_initial_set;
    assign cfg.final_set     = r_final_set;

    assign core_req.func       = t_func'(i_req.func);
    assign core_req.from_state = i_req.from_state;
    assign core_req.to_state   = i_req.to_state;
    assign core_req.symbol     = i_req.symbol;

    // The sequencer may hand over a response whenever the stage is empty or is
    // being emptied in this very cycle.
    assign core_rsp_free = !r_rsp_valid || o_rsp.ready;

    nae_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (core_req),
        .o_rsp_valid (core_rsp_valid),
        .i_rsp_free  (core_rsp_free),
        .o_rsp       (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= core_rsp_valid || (r_rsp_valid && !o_rsp.ready);
        end
        if (core_rsp_valid) begin
            r_rsp <= core_rsp;
        end
    end

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.sample_done = r_rsp.sample_done;
    assign o_rsp.accepted    = r_rsp.accepted;
    assign o_rsp.any_active  = r_rsp.any_active;
    assign o_rsp.bad_item    = r_rsp.bad_item;
endmodule
